// ===== rtl/tqm_pkg.sv =====
package tqm_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int VALUE_W = 32;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MERGED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] data;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } q_stat_t;

endpackage

// ===== rtl/tqm_if.sv =====
interface tqm_req_if import tqm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface tqm_rsp_if import tqm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0]       status;
  logic                      last;

  modport source (output valid, output value_out, output status, output last, input ready);
  modport sink (input valid, input value_out, input status, input last, output ready);
endinterface

// ===== rtl/tqm_queue.sv =====
module tqm_queue import tqm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  q_ctrl_t                   ctrl,
  output q_stat_t                   stat,
  output logic signed [VALUE_W-1:0] head_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic signed [VALUE_W-1:0] mem [QUEUE_DEPTH];

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          do_push;
  logic          do_pop;

  assign stat.empty  = (count == '0);
  assign stat.full   = (count == CW'(QUEUE_DEPTH));
  assign stat.single = (count == CW'(1));

  assign do_push = ctrl.push && !stat.full;
  assign do_pop  = ctrl.pop && !stat.empty;

  // Tail is head plus occupancy, wrapped once; the sum stays below twice the depth.
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(tail_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    if (do_pop) begin
      head_next = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctrl.data;
    end
    head_data <= mem[head];
  end

endmodule

// ===== rtl/two_queue_merge.sv =====
// Two bounded FIFO queues (A and B) of signed 32-bit values with a merge
// operation. A request with mode 0 or 1 appends its value to queue A or B and
// returns one response marked last: status accepted, or status full when that
// queue already holds QUEUE_DEPTH entries (the queue is then left unchanged).
// A request with mode 2 drains both queues into one run of responses with
// status merged: at each step the two heads are compared by one shared signed
// comparator and A's head is sent only when B's head is strictly greater, so
// ties go to B; once one queue is empty the rest of the other follows. The
// final response of the run carries last. A merge of two empty queues gives
// a single response with status empty. Mode 3 is ignored and gives no
// response. Timing: the response to an enqueue appears in the output register
// on the cycle after the request is taken. Every merge step first reads both
// queue heads from the registered memory read port (state S_READ) and then
// compares and pops in the following cycle (state S_EMIT); the request side
// is not ready for the whole merge. Output stalls hold the block in S_EMIT.
// There is no clearing pass after reset.
module two_queue_merge import tqm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  tqm_req_if.sink   req,
  tqm_rsp_if.source rsp
);

  state_t state;
  state_t state_next;

  q_ctrl_t qa_ctrl;
  q_ctrl_t qb_ctrl;
  q_stat_t qa_stat;
  q_stat_t qb_stat;
  logic signed [VALUE_W-1:0] qa_head;
  logic signed [VALUE_W-1:0] qb_head;

  // Output register holding one response until it is transferred.
  logic                      o_valid;
  logic signed [VALUE_W-1:0] o_value;
  logic [STATUS_W-1:0]       o_status;
  logic                      o_last;

  logic signed [VALUE_W-1:0] o_value_next;
  logic [STATUS_W-1:0]       o_status_next;
  logic                      o_last_next;
  logic                      o_load;

  logic accept;
  logic slot_free;
  logic take_a;
  logic emit;
  logic both_empty;
  logic final_one;

  tqm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue_a (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qa_ctrl),
    .stat      (qa_stat),
    .head_data (qa_head)
  );

  tqm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue_b (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qb_ctrl),
    .stat      (qb_stat),
    .head_data (qb_head)
  );

  // The output slot is free when empty or when its response leaves this cycle.
  assign slot_free  = !o_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && slot_free;
  assign accept     = req.valid && req.ready;
  assign both_empty = qa_stat.empty && qb_stat.empty;

  // The shared compare: A is chosen only if B is empty or B's head is greater.
  always_comb begin
    if (qa_stat.empty) begin
      take_a = 1'b0;
    end else if (qb_stat.empty) begin
      take_a = 1'b1;
    end else begin
      take_a = (qb_head > qa_head);
    end
  end

  // The response being sent is the final one when exactly one entry remains.
  assign final_one = (qa_stat.single && qb_stat.empty) || (qb_stat.single && qa_stat.empty);
  assign emit      = (state == S_EMIT) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.mode == MODE_MERGE) && !both_empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = final_one ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    qa_ctrl.push  = accept && (req.mode == MODE_ENQ_A);
    qa_ctrl.pop   = emit && take_a;
    qa_ctrl.data  = req.value;
    qb_ctrl.push  = accept && (req.mode == MODE_ENQ_B);
    qb_ctrl.pop   = emit && !take_a;
    qb_ctrl.data  = req.value;
    o_load        = 1'b0;
    o_value_next  = '0;
    o_status_next = ST_MERGED;
    o_last_next   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_ENQ_A: begin
              o_load        = 1'b1;
              o_status_next = qa_stat.full ? ST_FULL : ST_ACCEPTED;
            end
            MODE_ENQ_B: begin
              o_load        = 1'b1;
              o_status_next = qb_stat.full ? ST_FULL : ST_ACCEPTED;
            end
            MODE_MERGE: begin
              if (both_empty) begin
                o_load        = 1'b1;
                o_status_next = ST_EMPTY;
              end
            end
            default: begin
              o_load = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        o_load = 1'b0;
      end
      S_EMIT: begin
        if (emit) begin
          o_load        = 1'b1;
          o_value_next  = take_a ? qa_head : qb_head;
          o_status_next = ST_MERGED;
          o_last_next   = final_one;
        end
      end
      default: begin
        o_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_value  <= o_value_next;
      o_status <= o_status_next;
      o_last   <= o_last_next;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.value_out = o_value;
  assign rsp.status    = o_status;
  assign rsp.last      = o_last;

endmodule

// ===== rtl/tqm_checker.sv =====
module tqm_checker import tqm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic [MODE_W-1:0]         req_mode,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic signed [VALUE_W-1:0] rsp_value_out,
  input logic [STATUS_W-1:0]       rsp_status,
  input logic                      rsp_last
);

  // A pending response stays until it is transferred.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before transfer");

  // An enqueue answers on the very next cycle with a single final status.
  a_enq_resp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_ENQ_A || req_mode == MODE_ENQ_B)
    |=> rsp_valid && rsp_last && (rsp_status == ST_ACCEPTED || rsp_status == ST_FULL))
    else $error("enqueue response missing or malformed");

  // No new request is taken while a merge run is still unfinished.
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request taken in the middle of a merge run");

  // Responses other than merged values carry a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_MERGED) |-> (rsp_value_out == '0))
    else $error("nonzero value on a status response");

  // Only merged values may appear without the last mark.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> (rsp_status == ST_MERGED))
    else $error("status response not marked last");

endmodule

bind two_queue_merge tqm_checker u_tqm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_mode      (req.mode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_value_out (rsp.value_out),
  .rsp_status    (rsp.status),
  .rsp_last      (rsp.last)
);

// ===== bench/testbench.sv =====
module testbench;
  import tqm_pkg::*;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  // The stimulus stops once about this many requests have been queued
  // (ignored requests do not count).
  localparam int ITEM_TARGET = 170;

  // Both sides idle in about this many cycles out of a hundred.
  localparam int IDLE_PERCENT = 17;

  // Windows with no idling at all, one per side.
  localparam int SEND_STEADY_FROM = 90;
  localparam int SEND_STEADY_TO = 140;
  localparam int RECV_STEADY_FROM = 100;
  localparam int RECV_STEADY_TO = 160;

  // Once this many responses have arrived, the response side holds off for
  // a long stretch so that the output register fills and the request side
  // backs up.
  localparam int HOLD_AT_RESULT = 40;
  localparam int HOLD_CYCLES = 300;

  // A merge spends a read step and an emit step on every response, so a quiet
  // stretch of DRAIN_CYCLES after the last expected response catches a stray one.
  localparam int DRAIN_CYCLES = 16;

  // The watchdog limit covers the long hold-off several times over; no
  // other stretch without a transfer comes close to it.
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } response_t;

  logic clk;
  logic rst;

  tqm_req_if req_ch();
  tqm_rsp_if rsp_ch();

  two_queue_merge #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Requests waiting for the driver, and the responses the queue model says
  // the block owes us, oldest first.
  request_t  pending_requests[$];
  response_t expected_responses[$];

  // The testbench's own copy of the two queues.
  logic signed [VALUE_W-1:0] queue_a_model[$];
  logic signed [VALUE_W-1:0] queue_b_model[$];

  int counted_items = 0;
  int accepted_items = 0;
  int results_seen = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Picks a value that often lands on ties, on the extremes, or anywhere.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(8)) - 4;
      1: begin
        case ($urandom_range(5))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = 0;
          3: v = -1;
          4: v = VALUE_MIN + 1;
          default: v = VALUE_MAX - 1;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Next value of an ascending run, held at the top of the range.
  function automatic logic signed [VALUE_W-1:0] step_up(logic signed [VALUE_W-1:0] prev);
    longint sum;
    sum = longint'(prev) + longint'($urandom_range(1000));
    if (sum > longint'(VALUE_MAX)) begin
      sum = longint'(VALUE_MAX);
    end
    return sum[VALUE_W-1:0];
  endfunction

  task automatic add_request(input logic [MODE_W-1:0] mode,
                             input logic signed [VALUE_W-1:0] value);
    request_t r;
    r.mode = mode;
    r.value = value;
    pending_requests.push_back(r);
    if (mode != MODE_UNUSED) begin
      counted_items++;
    end
  endtask

  // Queues a_len values for A and b_len for B in a random interleaving,
  // then a merge if asked. When ordered is set, each queue gets an
  // ascending run so that the merge yields sorted output if both queues start empty.
  task automatic add_merge_run(input int a_len, input int b_len, input bit ordered,
                               input bit with_merge);
    logic signed [VALUE_W-1:0] a_next;
    logic signed [VALUE_W-1:0] b_next;
    a_next = pick_value();
    b_next = pick_value();
    while (a_len > 0 || b_len > 0) begin
      if (a_len > 0 && (b_len == 0 || $urandom_range(1) == 1)) begin
        add_request(MODE_ENQ_A, ordered ? a_next : pick_value());
        a_next = step_up(a_next);
        a_len--;
      end else begin
        add_request(MODE_ENQ_B, ordered ? b_next : pick_value());
        b_next = step_up(b_next);
        b_len--;
      end
    end
    if (with_merge) begin
      add_request(MODE_MERGE, pick_value());
    end
  endtask

  task automatic push_response(input logic signed [VALUE_W-1:0] value_out,
                               input logic [STATUS_W-1:0] status, input logic last);
    response_t r;
    r.value_out = value_out;
    r.status = status;
    r.last = last;
    expected_responses.push_back(r);
  endtask

  // Updates the queue model for one accepted request and appends the
  // responses that the request must produce.
  task automatic compute_responses(input logic [MODE_W-1:0] mode,
                                   input logic signed [VALUE_W-1:0] value);
    logic signed [VALUE_W-1:0] word;
    bit take_a;
    case (mode)
      MODE_ENQ_A: begin
        if (queue_a_model.size() < QUEUE_DEPTH_DEF) begin
          queue_a_model.push_back(value);
          push_response(0, ST_ACCEPTED, 1'b1);
        end else begin
          push_response(0, ST_FULL, 1'b1);
        end
      end
      MODE_ENQ_B: begin
        if (queue_b_model.size() < QUEUE_DEPTH_DEF) begin
          queue_b_model.push_back(value);
          push_response(0, ST_ACCEPTED, 1'b1);
        end else begin
          push_response(0, ST_FULL, 1'b1);
        end
      end
      MODE_MERGE: begin
        if (queue_a_model.size() == 0 && queue_b_model.size() == 0) begin
          push_response(0, ST_EMPTY, 1'b1);
        end
        while (queue_a_model.size() != 0 || queue_b_model.size() != 0) begin
          // A's head goes out only when B's head is strictly greater, so a
          // tie goes to B. An empty queue is never looked at.
          if (queue_a_model.size() == 0) begin
            take_a = 1'b0;
          end else if (queue_b_model.size() == 0) begin
            take_a = 1'b1;
          end else begin
            take_a = queue_b_model[0] > queue_a_model[0];
          end
          word = take_a ? queue_a_model.pop_front() : queue_b_model.pop_front();
          push_response(word, ST_MERGED,
                        queue_a_model.size() == 0 && queue_b_model.size() == 0);
        end
      end
      default: begin
        // The unused mode leaves the queues alone and gives nothing back.
      end
    endcase
  endtask

  // Request driver. An accepted transfer is handed to the queue model at
  // the edge where it happens; a new request is put up whenever the slot is
  // free, unless the sender decides to idle this cycle. During the long
  // hold-off on the response side it never idles, so the block is kept
  // under pressure and must stall its input.
  always @(posedge clk) begin
    request_t next_req;
    bit idle_now;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_ENQ_A;
      req_ch.value <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        compute_responses(req_ch.mode, req_ch.value);
        accepted_items++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        idle_now = hold_left == 0 &&
                   !(accepted_items >= SEND_STEADY_FROM && accepted_items < SEND_STEADY_TO) &&
                   $urandom_range(99) < IDLE_PERCENT;
        if (pending_requests.size() != 0 && !idle_now) begin
          next_req = pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode <= next_req.mode;
          req_ch.value <= next_req.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. Every transfer is compared field by field with the
  // oldest expected response; a response with nothing expected is an error
  // on its own. The same process decides the ready level for the next
  // cycle, including the one long hold-off.
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected: value_out %0d status %0d last %0d",
                   $time, rsp_ch.value_out, rsp_ch.status, rsp_ch.last);
          error_count++;
        end else begin
          want = expected_responses.pop_front();
          if (rsp_ch.value_out !== want.value_out) begin
            $display("%0t: value_out expected %0d actual %0d",
                     $time, want.value_out, rsp_ch.value_out);
            error_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d",
                     $time, want.last, rsp_ch.last);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        rsp_ch.ready <= 1'b0;
      end else if (results_seen >= RECV_STEADY_FROM && results_seen < RECV_STEADY_TO) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= $urandom_range(99) >= IDLE_PERCENT;
      end
    end
  end

  // Watchdog: too many cycles in a row without a transfer on either side
  // means the block has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** two_queue_merge: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int pick;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ENQ_A;
    req_ch.value = 0;
    rsp_ch.ready = 1'b0;

    // Directed part. A merge with nothing queued comes first.
    add_request(MODE_MERGE, 0);
    // Extremes on both sides: the merge sees a strict win for B, a tie at
    // the maximum, a loss for B and finally A draining alone.
    add_request(MODE_ENQ_A, VALUE_MIN);
    add_request(MODE_ENQ_A, -1);
    add_request(MODE_ENQ_A, VALUE_MAX);
    add_request(MODE_ENQ_B, VALUE_MAX);
    add_request(MODE_ENQ_B, 0);
    add_request(MODE_ENQ_B, VALUE_MIN);
    add_request(MODE_MERGE, VALUE_MAX);
    // The unused mode, with all value bits low and then high.
    add_request(MODE_UNUSED, 0);
    add_request(MODE_UNUSED, -1);
    // A plain tie, which must go to B.
    add_request(MODE_ENQ_A, 5);
    add_request(MODE_ENQ_B, 5);
    add_request(MODE_MERGE, -1);
    // Only B holds data, then only A.
    add_request(MODE_ENQ_B, 7);
    add_request(MODE_MERGE, 0);
    add_request(MODE_ENQ_A, 3);
    add_request(MODE_ENQ_A, 9);
    add_request(MODE_MERGE, 0);
    // Back to back merges: the second one finds both queues empty.
    add_request(MODE_MERGE, 0);

    // Both queues past full, so some enqueues are refused, then the
    // longest possible merge.
    add_merge_run(QUEUE_DEPTH_DEF + 2, QUEUE_DEPTH_DEF + 1, 1'b1, 1'b1);

    // Random part: mostly enqueue runs closed by a merge, with occasional
    // overflow runs, runs left open across the next one, and ignored items.
    while (counted_items < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        if ($urandom_range(1) == 1) begin
          add_merge_run(QUEUE_DEPTH_DEF + $urandom_range(1, 3), $urandom_range(4),
                        $urandom_range(1), 1'b1);
        end else begin
          add_merge_run($urandom_range(4), QUEUE_DEPTH_DEF + $urandom_range(1, 3),
                        $urandom_range(1), 1'b1);
        end
      end else if (pick < 12) begin
        add_request(MODE_UNUSED, pick_value());
      end else if (pick < 18) begin
        add_merge_run($urandom_range(1, 4), $urandom_range(3), 1'b0, 1'b0);
      end else begin
        add_merge_run($urandom_range(8), $urandom_range(8), $urandom_range(1), 1'b1);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid) begin
      @(posedge clk);
    end
    while (expected_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** two_queue_merge: PASSED **");
    end else begin
      $display("** two_queue_merge: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tqm_pkg.sv
rtl/tqm_if.sv
rtl/tqm_queue.sv
rtl/two_queue_merge.sv
rtl/tqm_checker.sv
bench/testbench.sv
